FILE: rtl/vaab_pkg.sv
// Shared types and constants for the voice allocator and envelope bank.
// No dependencies.
`default_nettype none
package vaab_pkg;

   localparam logic [23:0] LEVEL_ONE = 24'd8388608;

   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_NOTE_ON = 2'd1;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd2;
   localparam logic [1:0] CMD_ALL_OFF = 2'd3;

   localparam logic [1:0] MODE_POLY   = 2'd0;
   localparam logic [1:0] MODE_MONO   = 2'd1;
   localparam logic [1:0] MODE_UNISON = 2'd2;

   localparam logic [1:0] STAGE_ATTACK  = 2'd0;
   localparam logic [1:0] STAGE_DECAY   = 2'd1;
   localparam logic [1:0] STAGE_SUSTAIN = 2'd2;
   localparam logic [1:0] STAGE_RELEASE = 2'd3;

   localparam logic [2:0] CSR_MODE    = 3'd0;
   localparam logic [2:0] CSR_MAXV    = 3'd1;
   localparam logic [2:0] CSR_ATTACK  = 3'd2;
   localparam logic [2:0] CSR_DECAY   = 3'd3;
   localparam logic [2:0] CSR_RELEASE = 3'd4;
   localparam logic [2:0] CSR_SUSTAIN = 3'd5;

   // Datapath operation requested by the controller for the current slot.
   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_RELALL  = 3'd1,
      OP_NOTEOFF = 3'd2,
      OP_SCAN    = 3'd3,
      OP_START   = 3'd4,
      OP_TICK    = 3'd5
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       first;   // first slot of a scan: reset the candidate
   } cmd_type;

   typedef struct packed {
      logic free_found;   // a free slot was seen in this scan
      logic have_best;    // the scan holds a candidate
      logic report;       // the tick step left the slot active
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/voice_allocator_adsr_bank.sv
// Top level of the voice allocator and envelope bank.
// Depends on vaab_pkg, vaab_ctrl and vaab_dp.
`default_nettype none
// Each command word walks the voice slots one per clock (a tick walk pauses
// while the output register is stalled), and req_ready stays low until the
// walk ends. A tick walks every slot and then flags the last report; a
// note-off or all-notes-off walks every slot; a note-on scans min(max_voices,
// MAX_VOICES) slots and starts a voice per allocation (UNISON_COUNT allocations
// in unison mode), after an all-notes-off walk in mono mode. A note-on with max_voices
// zero outside mono mode is dropped at once. Each report waits in a hold
// register so that the last flag can be set, then leaves through the output
// register.
module voice_allocator_adsr_bank #(
   parameter int MAX_VOICES   = 16,
   parameter int UNISON_COUNT = 3
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic [1:0]  req_command,
   input  wire  logic [6:0]  req_note,
   input  wire  logic [6:0]  req_velocity,
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic [3:0]        rsp_voice_index,
   output logic [6:0]        rsp_voice_note,
   output logic [6:0]        rsp_voice_velocity,
   output logic [23:0]       rsp_env_level,
   output logic [1:0]        rsp_env_stage,
   output logic [2:0]        rsp_unison_slot,
   output logic              rsp_last,
   input  wire  logic        csr_write,
   input  wire  logic [2:0]  csr_index,
   input  wire  logic [23:0] csr_data
);
   localparam int SW = $clog2(MAX_VOICES);
   localparam int LW = $clog2(MAX_VOICES + 1);

   logic [1:0]  mode_ff;
   logic [4:0]  maxv_ff;
   logic [23:0] att_ff, dec_ff, rel_ff, sus_ff;
   logic [6:0]  note_ff, vel_ff;
   logic [LW-1:0] limit;
   logic [23:0] cap_att, cap_dec, cap_rel, cap_sus;

   vaab_pkg::cmd_type cmd;
   vaab_pkg::sts_type sts;
   logic [SW-1:0] slot;
   logic [2:0] uni;
   logic out_load, out_last_chk, out_free;
   logic [6:0] cur_key, cur_vel;
   logic [23:0] cur_level;
   logic [1:0] cur_stage;
   logic [2:0] cur_uni;

   // Held report: one pending, one in the output register.
   logic hold_ff;
   logic [3:0] h_idx_ff;
   logic [6:0] h_key_ff, h_vel_ff;
   logic [23:0] h_lvl_ff;
   logic [1:0] h_stg_ff;
   logic [2:0] h_uni_ff;

   function automatic logic [23:0] cap_one(input logic [23:0] v);
      cap_one = (v > vaab_pkg::LEVEL_ONE) ? vaab_pkg::LEVEL_ONE : v;
   endfunction

   assign cap_att = cap_one(att_ff);
   assign cap_dec = cap_one(dec_ff);
   assign cap_rel = cap_one(rel_ff);
   assign cap_sus = cap_one(sus_ff);
   assign limit = (32'(maxv_ff) > MAX_VOICES) ? LW'(MAX_VOICES) : LW'(maxv_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
         maxv_ff <= 5'd8;
         att_ff  <= 24'd175;
         dec_ff  <= 24'd66;
         rel_ff  <= 24'd41;
         sus_ff  <= 24'd5872026;
      end else if (csr_write) begin
         case (csr_index)
            vaab_pkg::CSR_MODE:    mode_ff <= csr_data[1:0];
            vaab_pkg::CSR_MAXV:    maxv_ff <= csr_data[4:0];
            vaab_pkg::CSR_ATTACK:  att_ff  <= csr_data;
            vaab_pkg::CSR_DECAY:   dec_ff  <= csr_data;
            vaab_pkg::CSR_RELEASE: rel_ff  <= csr_data;
            vaab_pkg::CSR_SUSTAIN: sus_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Capture the command word's payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         note_ff <= req_note;
         vel_ff  <= req_velocity;
      end
   end

   vaab_ctrl #(.MAX_VOICES(MAX_VOICES), .UNISON_COUNT(UNISON_COUNT)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_command,
      .mode(mode_ff), .limit, .cmd, .slot, .uni, .sts,
      .out_load, .out_last_chk, .out_free
   );

   vaab_dp #(.MAX_VOICES(MAX_VOICES)) u_dp (
      .clock, .reset, .cmd, .slot, .uni,
      .note_in(note_ff), .vel_in(vel_ff),
      .attack(cap_att), .decay(cap_dec), .release_s(cap_rel), .sustain(cap_sus),
      .sts, .cur_key, .cur_vel, .cur_level, .cur_stage, .cur_uni
   );

   // A report waits in the hold register until the next one (or the end of
   // the tick) tells whether it is the last; then it moves to the output.
   assign out_free = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (out_free) begin
         rsp_valid <= 1'b0;
         if (out_load) begin
            hold_ff <= 1'b1;
            if (hold_ff) rsp_valid <= 1'b1;
         end else if (out_last_chk) begin
            hold_ff <= 1'b0;
            if (hold_ff) rsp_valid <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && (out_load || out_last_chk)) begin
         rsp_voice_index    <= h_idx_ff;
         rsp_voice_note     <= h_key_ff;
         rsp_voice_velocity <= h_vel_ff;
         rsp_env_level      <= h_lvl_ff;
         rsp_env_stage      <= h_stg_ff;
         rsp_unison_slot    <= h_uni_ff;
         rsp_last           <= out_last_chk;
      end
      if (out_free && out_load) begin
         h_idx_ff <= 4'(slot);
         h_key_ff <= cur_key;
         h_vel_ff <= cur_vel;
         h_lvl_ff <= cur_level;
         h_stg_ff <= cur_stage;
         h_uni_ff <= cur_uni;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/vaab_ctrl.sv
// Controller for the voice bank: walks the slots for each command word.
// Depends on vaab_pkg.
`default_nettype none
module vaab_ctrl #(
   parameter int MAX_VOICES   = 16,
   parameter int UNISON_COUNT = 3
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 req_valid,
   output logic                       req_ready,
   input  wire  logic [1:0]           req_command,
   input  wire  logic [1:0]           mode,
   input  wire  logic [$clog2(MAX_VOICES+1)-1:0] limit,
   output vaab_pkg::cmd_type          cmd,
   output logic [$clog2(MAX_VOICES)-1:0] slot,
   output logic [2:0]                 uni,
   input  vaab_pkg::sts_type          sts,
   output logic                       out_load,
   output logic                       out_last_chk,
   input  wire  logic                 out_free
);
   localparam int SW = $clog2(MAX_VOICES);
   localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_VOICES - 1);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RELALL = 7'b0000010,
      ST_OFF    = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_START  = 7'b0010000,
      ST_TICK   = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [2:0] uni_ff, uni_in;
   logic [1:0] kind_ff, kind_in;
   logic [SW:0] slot_ext;

   assign slot     = slot_ff;
   assign uni      = uni_ff;
   assign slot_ext = {1'b0, slot_ff};
   assign req_ready = (state_ff == ST_IDLE);

   // Next-state logic: one slot per cycle in every walk, the tick walk only while out_free is high.
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      uni_in   = uni_ff;
      kind_in  = kind_ff;
      cmd.op   = vaab_pkg::OP_NONE;
      cmd.first = (slot_ff == '0);
      out_load = 1'b0;
      out_last_chk = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            slot_in = '0;
            uni_in  = '0;
            if (req_valid) begin
               kind_in = req_command;
               case (req_command)
                  vaab_pkg::CMD_TICK:     state_in = ST_TICK;
                  vaab_pkg::CMD_NOTE_OFF: state_in = ST_OFF;
                  vaab_pkg::CMD_ALL_OFF:  state_in = ST_RELALL;
                  default: begin
                     if (mode == vaab_pkg::MODE_MONO) state_in = ST_RELALL;
                     else if (limit == '0) state_in = ST_IDLE;
                     else state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_RELALL: begin
            cmd.op = vaab_pkg::OP_RELALL;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == SLOT_LAST) begin
               slot_in = '0;
               if (kind_ff == vaab_pkg::CMD_NOTE_ON && limit != '0) state_in = ST_SCAN;
               else state_in = ST_IDLE;
            end
         end
         ST_OFF: begin
            cmd.op = vaab_pkg::OP_NOTEOFF;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == SLOT_LAST) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.op = vaab_pkg::OP_SCAN;
            slot_in = slot_ff + 1'b1;
            if (slot_ext + 1'b1 >= limit) begin
               slot_in  = '0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.op = vaab_pkg::OP_START;
            state_in = ST_IDLE;
            if (mode == vaab_pkg::MODE_UNISON && 32'(uni_ff) + 1 < UNISON_COUNT) begin
               uni_in   = uni_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_TICK: begin
            cmd.op = vaab_pkg::OP_TICK;
            if (out_free) begin
               if (sts.report) out_load = 1'b1;
               slot_in = slot_ff + 1'b1;
               if (slot_ff == SLOT_LAST) state_in = ST_EMIT;
            end else begin
               cmd.op = vaab_pkg::OP_NONE;
            end
         end
         ST_EMIT: begin
            // Flag the held report as the final one of the tick.
            out_last_chk = 1'b1;
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         uni_ff   <= '0;
         kind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         uni_ff   <= uni_in;
         kind_ff  <= kind_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/vaab_dp.sv
// Datapath for the voice bank: per-slot voice state, steal scan and envelope step.
// Depends on vaab_pkg.
`default_nettype none
module vaab_dp #(
   parameter int MAX_VOICES = 16
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  vaab_pkg::cmd_type          cmd,
   input  wire  logic [$clog2(MAX_VOICES)-1:0] slot,
   input  wire  logic [2:0]           uni,
   input  wire  logic [6:0]           note_in,
   input  wire  logic [6:0]           vel_in,
   input  wire  logic [23:0]          attack,
   input  wire  logic [23:0]          decay,
   input  wire  logic [23:0]          release_s,
   input  wire  logic [23:0]          sustain,
   output vaab_pkg::sts_type          sts,
   output logic [6:0]                 cur_key,
   output logic [6:0]                 cur_vel,
   output logic [23:0]                cur_level,
   output logic [1:0]                 cur_stage,
   output logic [2:0]                 cur_uni
);
   localparam int SW = $clog2(MAX_VOICES);

   logic [MAX_VOICES-1:0] act_ff;
   logic [1:0]  stage_ff [MAX_VOICES];
   logic [23:0] level_ff [MAX_VOICES];
   logic [6:0]  key_ff   [MAX_VOICES];
   logic [6:0]  vel_ff   [MAX_VOICES];
   logic [2:0]  uni_ff   [MAX_VOICES];

   logic [SW-1:0] best_ff, best_in, free_ff, free_in;
   logic free_found_ff, free_found_in, have_ff, have_in;
   logic [SW-1:0] tgt;

   logic [24:0] sum, dif;
   logic [23:0] lvl_new;
   logic [1:0]  stg_new;
   logic        act_new;

   // Current slot view for the tick step.
   assign cur_key   = key_ff[slot];
   assign cur_vel   = vel_ff[slot];
   assign cur_uni   = uni_ff[slot];
   assign cur_level = lvl_new;
   assign cur_stage = stg_new;

   assign sts.free_found = free_found_ff;
   assign sts.have_best  = have_ff;
   assign sts.report     = act_ff[slot] && act_new;

   // Envelope step for the current slot.
   always_comb begin
      sum = {1'b0, level_ff[slot]} + {1'b0, attack};
      dif = 25'd0;
      lvl_new = level_ff[slot];
      stg_new = stage_ff[slot];
      act_new = act_ff[slot];
      case (stage_ff[slot])
         vaab_pkg::STAGE_ATTACK: begin
            if (sum >= {1'b0, vaab_pkg::LEVEL_ONE}) begin
               lvl_new = vaab_pkg::LEVEL_ONE;
               stg_new = vaab_pkg::STAGE_DECAY;
            end else lvl_new = sum[23:0];
         end
         vaab_pkg::STAGE_DECAY: begin
            dif = {1'b0, level_ff[slot]} - {1'b0, decay};
            if (dif[24] || dif[23:0] <= sustain) begin
               lvl_new = sustain;
               stg_new = vaab_pkg::STAGE_SUSTAIN;
            end else lvl_new = dif[23:0];
         end
         vaab_pkg::STAGE_SUSTAIN: lvl_new = level_ff[slot];
         default: begin
            dif = {1'b0, level_ff[slot]} - {1'b0, release_s};
            if (dif[24] || dif[23:0] == '0) begin
               lvl_new = '0;
               act_new = 1'b0;
            end else lvl_new = dif[23:0];
         end
      endcase
   end

   // Steal scan: first free slot, else an order-dependent release/low-note pick.
   always_comb begin
      free_found_in = free_found_ff;
      free_in = free_ff;
      best_in = best_ff;
      have_in = have_ff;
      if (cmd.op == vaab_pkg::OP_SCAN) begin
         if (cmd.first) begin
            free_found_in = !act_ff[slot];
            free_in = slot;
            best_in = slot;
            have_in = 1'b1;
         end else begin
            if (!free_found_ff && !act_ff[slot]) begin
               free_found_in = 1'b1;
               free_in = slot;
            end
            if (stage_ff[slot] == vaab_pkg::STAGE_RELEASE &&
                stage_ff[best_ff] != vaab_pkg::STAGE_RELEASE) best_in = slot;
            else if (key_ff[slot] < key_ff[best_ff]) best_in = slot;
         end
      end
      tgt = free_found_ff ? free_ff : best_ff;
   end

   always_ff @(posedge clock) begin
      free_found_ff <= free_found_in;
      free_ff <= free_in;
      best_ff <= best_in;
      have_ff <= have_in;
   end

   // Voice state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
         for (int i = 0; i < MAX_VOICES; i++) begin
            stage_ff[i] <= vaab_pkg::STAGE_ATTACK;
            level_ff[i] <= '0;
            key_ff[i]   <= 7'd60;
            vel_ff[i]   <= 7'd102;
            uni_ff[i]   <= '0;
         end
      end else begin
         case (cmd.op)
            vaab_pkg::OP_RELALL:
               if (act_ff[slot]) stage_ff[slot] <= vaab_pkg::STAGE_RELEASE;
            vaab_pkg::OP_NOTEOFF:
               if (act_ff[slot] && key_ff[slot] == note_in)
                  stage_ff[slot] <= vaab_pkg::STAGE_RELEASE;
            vaab_pkg::OP_START: begin
               act_ff[tgt]   <= 1'b1;
               stage_ff[tgt] <= vaab_pkg::STAGE_ATTACK;
               level_ff[tgt] <= '0;
               key_ff[tgt]   <= note_in;
               vel_ff[tgt]   <= vel_in;
               uni_ff[tgt]   <= uni;
            end
            vaab_pkg::OP_TICK:
               if (act_ff[slot]) begin
                  act_ff[slot]   <= act_new;
                  stage_ff[slot] <= stg_new;
                  level_ff[slot] <= lvl_new;
               end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the voice allocator and envelope bank.
// Depends on vaab_pkg and the voice_allocator_adsr_bank RTL.
`timescale 1ns / 1ps
module tb;

   localparam int SLOTS      = 16;
   localparam int UNISON_N   = 3;
   localparam int WATCH_MAX  = 5000;
   localparam int SETTLE     = 120;

   // One voice report as it leaves the block.
   typedef struct packed {
      logic [3:0]  index;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [23:0] level;
      logic [1:0]  stage;
      logic [2:0]  unison;
      logic        last;
   } voice_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = vaab_pkg::CMD_TICK;
   logic [6:0]  req_note = '0;
   logic [6:0]  req_velocity = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_voice_index;
   logic [6:0]  rsp_voice_note;
   logic [6:0]  rsp_voice_velocity;
   logic [23:0] rsp_env_level;
   logic [1:0]  rsp_env_stage;
   logic [2:0]  rsp_unison_slot;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = vaab_pkg::CSR_MODE;
   logic [23:0] csr_data = '0;

   voice_allocator_adsr_bank u_top (.*);

   always #1 clock = ~clock;

   // Shadow copy of the bank: configuration and per-slot voice state.
   logic [1:0]  mode_r;
   logic [4:0]  maxv_r;
   logic [23:0] attack_r, decay_r, release_r, sustain_r;
   logic        v_active [SLOTS];
   logic [1:0]  v_stage  [SLOTS];
   logic [23:0] v_level  [SLOTS];
   logic [6:0]  v_key    [SLOTS];
   logic [6:0]  v_vel    [SLOTS];
   logic [2:0]  v_uni    [SLOTS];

   voice_report_type pending_reports[$];
   int errors      = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int holdoff     = 0;
   int quiet_count = 0;

   function automatic logic [23:0] cap_one(input logic [23:0] v);
      return (v > vaab_pkg::LEVEL_ONE) ? vaab_pkg::LEVEL_ONE : v;
   endfunction

   function automatic void clear_voice(input int i);
      v_active[i] = 1'b0;
      v_stage[i]  = vaab_pkg::STAGE_ATTACK;
      v_level[i]  = '0;
      v_key[i]    = 7'd60;
      v_vel[i]    = 7'd102;
      v_uni[i]    = '0;
   endfunction

   function automatic void release_voices();
      for (int i = 0; i < SLOTS; i++)
         if (v_active[i]) v_stage[i] = vaab_pkg::STAGE_RELEASE;
   endfunction

   // Free slot first; otherwise the order-dependent steal scan.
   function automatic int choose_voice();
      int lim;
      int best;
      lim = (maxv_r > SLOTS) ? SLOTS : int'(maxv_r);
      best = -1;
      for (int i = 0; i < lim; i++)
         if (!v_active[i]) return i;
      for (int i = 0; i < lim; i++) begin
         if (best < 0) best = i;
         else if (v_stage[i] == vaab_pkg::STAGE_RELEASE &&
                  v_stage[best] != vaab_pkg::STAGE_RELEASE) best = i;
         else if (v_key[i] < v_key[best]) best = i;
      end
      return best;
   endfunction

   function automatic logic start_voice(input logic [6:0] nt, input logic [6:0] vl,
                                        input logic [2:0] un);
      int idx;
      idx = choose_voice();
      if (idx < 0) return 1'b0;
      clear_voice(idx);
      v_active[idx] = 1'b1;
      v_key[idx]    = nt;
      v_vel[idx]    = vl;
      v_uni[idx]    = un;
      return 1'b1;
   endfunction

   function automatic void step_envelope(input int i);
      longint lvl;
      longint sus;
      lvl = v_level[i];
      sus = cap_one(sustain_r);
      case (v_stage[i])
         vaab_pkg::STAGE_ATTACK: begin
            lvl += cap_one(attack_r);
            if (lvl >= vaab_pkg::LEVEL_ONE) begin
               lvl = vaab_pkg::LEVEL_ONE;
               v_stage[i] = vaab_pkg::STAGE_DECAY;
            end
         end
         vaab_pkg::STAGE_DECAY: begin
            lvl -= cap_one(decay_r);
            if (lvl <= sus) begin
               lvl = sus;
               v_stage[i] = vaab_pkg::STAGE_SUSTAIN;
            end
         end
         vaab_pkg::STAGE_SUSTAIN: ;
         default: begin
            lvl -= cap_one(release_r);
            if (lvl <= 0) begin
               lvl = 0;
               v_active[i] = 1'b0;
            end
         end
      endcase
      v_level[i] = lvl[23:0];
   endfunction

   // Apply one accepted word to the shadow state; ticks queue their reports.
   function automatic void apply_word(input logic [1:0] cmd, input logic [6:0] nt,
                                      input logic [6:0] vl);
      voice_report_type rep;
      int first;
      case (cmd)
         vaab_pkg::CMD_NOTE_ON: begin
            if (mode_r == vaab_pkg::MODE_MONO) begin
               release_voices();
               void'(start_voice(nt, vl, 3'd0));
            end else if (mode_r == vaab_pkg::MODE_UNISON) begin
               for (int u = 0; u < UNISON_N; u++)
                  if (!start_voice(nt, vl, u[2:0])) break;
            end else begin
               void'(start_voice(nt, vl, 3'd0));
            end
         end
         vaab_pkg::CMD_NOTE_OFF: begin
            for (int i = 0; i < SLOTS; i++)
               if (v_active[i] && v_key[i] == nt) v_stage[i] = vaab_pkg::STAGE_RELEASE;
         end
         vaab_pkg::CMD_ALL_OFF: release_voices();
         default: begin
            first = pending_reports.size();
            for (int i = 0; i < SLOTS; i++) begin
               if (v_active[i]) begin
                  step_envelope(i);
                  if (v_active[i]) begin
                     rep = '{index: i[3:0], note: v_key[i], velocity: v_vel[i],
                             level: v_level[i], stage: v_stage[i], unison: v_uni[i],
                             last: 1'b0};
                     pending_reports = {pending_reports, rep};
                  end
               end
            end
            if (pending_reports.size() > first)
               pending_reports[pending_reports.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   // Input monitor: every accepted word goes through the shadow model.
   always @(posedge clock)
      if (!reset && req_valid && req_ready) apply_word(req_command, req_note, req_velocity);

   // Result checker: each accepted word is compared with the oldest report.
   always @(posedge clock) begin
      voice_report_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_voice_index, rsp_voice_note, rsp_voice_velocity, rsp_env_level,
                 rsp_env_stage, rsp_unison_slot, rsp_last};
         if (pending_reports.size() == 0)
            report_mismatch($sformatf("unexpected word %p", got));
         else begin
            want = pending_reports.pop_front();
            if (got !== want)
               report_mismatch($sformatf("got %p want %p", got, want));
         end
      end
   end

   // Receiver: long hold-off when requested, else random stalls.
   always @(negedge clock) begin
      if (holdoff > 0) begin
         rsp_ready <= 1'b0;
         holdoff = holdoff - 1;
      end else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog on cycles with no handshake of any kind.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write || reset)
         quiet_count <= 0;
      else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count >= WATCH_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [1:0] cmd, input logic [6:0] nt,
                            input logic [6:0] vl);
      int gap;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 60) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_note     <= nt;
      req_velocity <= vl;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Drain all reports, then let a trailing note-on scan finish.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         vaab_pkg::CSR_MODE:    mode_r    = val[1:0];
         vaab_pkg::CSR_MAXV:    maxv_r    = val[4:0];
         vaab_pkg::CSR_ATTACK:  attack_r  = val;
         vaab_pkg::CSR_DECAY:   decay_r   = val;
         vaab_pkg::CSR_RELEASE: release_r = val;
         vaab_pkg::CSR_SUSTAIN: sustain_r = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input logic [1:0] md, input logic [4:0] mv,
                            input logic [23:0] att, input logic [23:0] dec,
                            input logic [23:0] rel, input logic [23:0] sus);
      wait_idle();
      write_reg(vaab_pkg::CSR_MODE, {22'd0, md});
      write_reg(vaab_pkg::CSR_MAXV, {19'd0, mv});
      write_reg(vaab_pkg::CSR_ATTACK, att);
      write_reg(vaab_pkg::CSR_DECAY, dec);
      write_reg(vaab_pkg::CSR_RELEASE, rel);
      write_reg(vaab_pkg::CSR_SUSTAIN, sus);
   endtask

   // Random word: mostly ticks and note-ons on a small cluster of keys.
   task automatic send_random();
      int pick;
      logic [1:0] cmd;
      logic [6:0] nt;
      pick = $urandom_range(99);
      if (pick < 42)      cmd = vaab_pkg::CMD_TICK;
      else if (pick < 72) cmd = vaab_pkg::CMD_NOTE_ON;
      else if (pick < 92) cmd = vaab_pkg::CMD_NOTE_OFF;
      else                cmd = vaab_pkg::CMD_ALL_OFF;
      nt = ($urandom_range(9) < 7) ? 7'(60 + $urandom_range(7)) : 7'($urandom_range(127));
      send_word(cmd, nt, 7'($urandom_range(127)));
   endtask

   // Field extremes under reset settings.
   task automatic test_directed();
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd0, 7'd0);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd127, 7'd127);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd60, 7'd85);
      send_word(vaab_pkg::CMD_TICK, 7'd127, 7'd127);
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
      send_word(vaab_pkg::CMD_NOTE_OFF, 7'd127, 7'd0);
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd42);
      send_word(vaab_pkg::CMD_ALL_OFF, 7'd0, 7'd0);
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
   endtask

   // Large steps walk voices through every stage, down to inactive.
   task automatic test_stages();
      configure(vaab_pkg::MODE_POLY, 5'd16, 24'd3000000, 24'd1000000, 24'd2500000,
                24'd6000000);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd64, 7'd100);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd65, 7'd50);
      repeat (6) send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
      send_word(vaab_pkg::CMD_NOTE_OFF, 7'd64, 7'd0);
      repeat (4) send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
      // Steps and sustain above one saturate to one.
      configure(vaab_pkg::MODE_POLY, 5'd16, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'hFFFFFF);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd10, 7'd1);
      repeat (3) send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
      send_word(vaab_pkg::CMD_ALL_OFF, 7'd0, 7'd0);
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
   endtask

   // Mono, unison, undefined mode, zero and oversized voice counts, stealing.
   task automatic test_modes();
      configure(vaab_pkg::MODE_MONO, 5'd4, 24'd4000000, 24'd0, 24'd8388608, 24'd0);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd50, 7'd20);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd51, 7'd21);
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
      configure(vaab_pkg::MODE_UNISON, 5'd4, 24'd0, 24'd8388608, 24'd1, 24'd8388608);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd70, 7'd30);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd40, 7'd31);
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
      configure(2'd3, 5'd0, 24'd8388608, 24'd1, 24'd0, 24'd1);
      send_word(vaab_pkg::CMD_NOTE_ON, 7'd33, 7'd33);
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
      configure(2'd3, 5'd31, 24'd700000, 24'd300000, 24'd900000, 24'd2000000);
      for (int i = 0; i < 18; i++) send_word(vaab_pkg::CMD_NOTE_ON, 7'(90 - i), 7'(i));
      send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_random();
      idle_pct  = 0;
      stall_pct = 0;
   endtask

   // Receiver holds off while ticks keep coming, so the input backs up.
   task automatic test_backpressure();
      configure(vaab_pkg::MODE_POLY, 5'd16, 24'd500000, 24'd200000, 24'd100000,
                24'd3000000);
      for (int i = 0; i < 12; i++)
         send_word(vaab_pkg::CMD_NOTE_ON, 7'(20 + i), 7'(100 + i));
      @(posedge clock);
      holdoff = 400;
      repeat (10) send_word(vaab_pkg::CMD_TICK, 7'd0, 7'd0);
   endtask

   initial begin
      mode_r = vaab_pkg::MODE_POLY;
      maxv_r = 5'd8;
      attack_r = 24'd175;
      decay_r = 24'd66;
      release_r = 24'd41;
      sustain_r = 24'd5872026;
      for (int i = 0; i < SLOTS; i++) clear_voice(i);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_stages();
      test_modes();
      configure(vaab_pkg::MODE_POLY, 5'd6, 24'd1500000, 24'd800000, 24'd1200000,
                24'd4000000);
      test_random(100, 0, 0);
      configure(vaab_pkg::MODE_UNISON, 5'd16, 24'd2000000, 24'd600000, 24'd700000,
                24'd5000000);
      test_random(100, 88, 0);
      configure(vaab_pkg::MODE_MONO, 5'd3, 24'd3000000, 24'd1500000, 24'd2000000,
                24'd1000000);
      test_random(90, 0, 88);
      configure(vaab_pkg::MODE_POLY, 5'd2, 24'd900000, 24'd400000, 24'd500000,
                24'd6500000);
      test_random(90, 13, 13);
      test_backpressure();

      wait_idle();
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
